// File: hw/rtl/brf_pkg.sv
// Package for the bitmap range find and fill unit.
// Holds the command codes, field widths and the queued command descriptor.
// Depends on nothing; every other file of the unit imports it.
`default_nettype none

package brf_pkg;

    // Command codes carried in the slave-side tuser bit.
    localparam logic CMD_FIND = 1'b0;
    localparam logic CMD_FILL = 1'b1;

    // Field widths of the stream payloads.
    localparam int START_W  = 12;
    localparam int END_W    = 13;
    localparam int POS_W    = 12;
    localparam int S_DATA_W = 32;
    localparam int M_DATA_W = 16;

    // Depth of the queue between the front and back parts.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    // Operation after classification; an empty range needs no store access.
    typedef enum logic [1:0] {
        OP_NONE,
        OP_FIND,
        OP_FILL
    } op_t;

    typedef struct packed {
        op_t                op;
        logic [START_W-1:0] range_start;
        logic [END_W-1:0]   range_end;
        logic               bit_value;
    } cmd_t;

endpackage

`default_nettype wire

// File: hw/rtl/bitmap_range_find_and_fill_unit.sv
// Top level of the bitmap range find and fill unit.
// Instantiates brf_front, brf_queue and brf_back; depends on brf_pkg.
`default_nettype none

// The unit keeps a bitmap of NUM_WORDS words of WORD_W bits, with bit
// positions counted from the most significant bit of word 0 upward. A find
// command returns the first position in [range_start, range_end) whose bit
// equals bit_value; a fill command writes bit_value over that range. Every
// command produces exactly one result transfer; fills and finds without a
// match report found = 0 and position = 0. range_end is clamped to the store
// size, and a range whose start is not below its end touches nothing. After
// reset the unit runs a clearing pass over every word of its memory;
// s_axis_tready stays low during reset and for the first cycle after it, and
// up to two commands may then be taken into the two-entry queue while the
// pass is still running; they start once it ends. Commands run one at a
// time: a command walks the memory from word 0 at one word per cycle through
// its read port and its write port until it passes the end of its range. A
// find that hits stops early at the word that holds the match, and an empty
// range goes straight to its result. A result that waits in the output register
// keeps the next finished command waiting until it is taken. The front queue
// keeps accepting while a command runs or a result waits in the output
// register.
module bitmap_range_find_and_fill_unit #(
    parameter int WORD_W    = 64,
    parameter int NUM_WORDS = 64
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         s_axis_tvalid,
    output logic                              s_axis_tready,
    // range_start [11:0], range_end [24:12], bit_value [25], zero [31:26]
    input  wire logic [brf_pkg::S_DATA_W-1:0] s_axis_tdata,
    // command [0]
    input  wire logic                         s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  wire logic                         m_axis_tready,
    // position [11:0], zero [15:12]
    output logic [brf_pkg::M_DATA_W-1:0]      m_axis_tdata,
    // found [0]
    output logic                              m_axis_tuser
);
    import brf_pkg::*;

    logic             push;
    cmd_t             push_cmd;
    logic             queue_full;
    logic             q_valid;
    logic             q_pop;
    cmd_t             q_cmd;
    logic [POS_W-1:0] res_position;

    brf_front #(
        .WORD_W    (WORD_W),
        .NUM_WORDS (NUM_WORDS)
    ) u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .queue_full    (queue_full),
        .push          (push),
        .push_cmd      (push_cmd)
    );

    brf_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_cmd  (push_cmd),
        .full      (queue_full),
        .pop       (q_pop),
        .not_empty (q_valid),
        .head_cmd  (q_cmd)
    );

    brf_back #(
        .WORD_W    (WORD_W),
        .NUM_WORDS (NUM_WORDS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_cmd        (q_cmd),
        .q_pop        (q_pop),
        .res_valid    (m_axis_tvalid),
        .res_found    (m_axis_tuser),
        .res_position (res_position),
        .res_ready    (m_axis_tready)
    );

    assign m_axis_tdata = {{(M_DATA_W - POS_W){1'b0}}, res_position};

endmodule

`default_nettype wire

// File: hw/rtl/brf_front.sv
// Front part of the bitmap range find and fill unit: accepts commands,
// clamps the range end to the store size and classifies each command.
// Depends on brf_pkg.
`default_nettype none

module brf_front #(
    parameter int WORD_W    = 64,
    parameter int NUM_WORDS = 64
) (
    input  wire logic                         s_axis_tvalid,
    output logic                              s_axis_tready,
    input  wire logic [brf_pkg::S_DATA_W-1:0] s_axis_tdata,
    input  wire logic                         s_axis_tuser,
    input  wire logic                         queue_full,
    output logic                              push,
    output brf_pkg::cmd_t                     push_cmd
);
    import brf_pkg::*;

    localparam int TOTAL_BITS = NUM_WORDS * WORD_W;

    logic [START_W-1:0] range_start;
    logic [END_W-1:0]   range_end;
    logic [END_W-1:0]   end_clamped;
    logic               bit_value;

    assign range_start = s_axis_tdata[START_W-1:0];
    assign range_end   = s_axis_tdata[START_W+END_W-1:START_W];
    assign bit_value   = s_axis_tdata[START_W+END_W];

    always_comb
    begin
        end_clamped = range_end;
        if (int'(range_end) > TOTAL_BITS)
        begin
            end_clamped = END_W'(TOTAL_BITS);
        end
        push_cmd.range_start = range_start;
        push_cmd.range_end   = end_clamped;
        push_cmd.bit_value   = bit_value;
        if ({1'b0, range_start} >= end_clamped)
        begin
            push_cmd.op = OP_NONE;
        end
        else if (s_axis_tuser == CMD_FILL)
        begin
            push_cmd.op = OP_FILL;
        end
        else
        begin
            push_cmd.op = OP_FIND;
        end
    end

    assign s_axis_tready = !queue_full;
    assign push          = s_axis_tvalid && !queue_full;

endmodule

`default_nettype wire

// File: hw/rtl/brf_queue.sv
// Short command queue between the front and back parts of the unit.
// Holds classified command descriptors in arrival order.
// Depends on brf_pkg.
`default_nettype none

module brf_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire brf_pkg::cmd_t push_cmd,
    output logic               full,
    input  wire logic          pop,
    output logic               not_empty,
    output brf_pkg::cmd_t      head_cmd
);
    import brf_pkg::*;

    cmd_t              slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic              ready_reg;
    logic              do_push;
    logic              do_pop;

    // The queue reports itself full during reset and in the first cycle after
    // it, so that no transfer is taken while the pointers are held.
    assign full      = (count_reg == QCNT_W'(QUEUE_DEPTH)) || !ready_reg;
    assign not_empty = (count_reg != '0);
    assign head_cmd  = slot_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
            ready_reg  <= 1'b0;
        end
        else
        begin
            ready_reg <= 1'b1;
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // The fill level never exceeds the number of slots.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("command queue over capacity");

    // A push into a queue that was full is refused and leaves the level alone.
    a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
        (full && push && !pop) |=> full)
        else $error("command queue lost its full level");

    // Popping the only entry without a push empties the queue.
    a_pop_last: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == QCNT_W'(1) && pop && !push) |=> !not_empty)
        else $error("command queue not empty after last pop");

endmodule

`default_nettype wire

// File: hw/rtl/brf_back.sv
// Back part of the bitmap range find and fill unit: owns the bitmap memory,
// clears it after reset, walks words for find and fill, holds the result.
// Depends on brf_pkg.
`default_nettype none

module brf_back #(
    parameter int WORD_W    = 64,
    parameter int NUM_WORDS = 64
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      q_valid,
    input  wire brf_pkg::cmd_t             q_cmd,
    output logic                           q_pop,
    output logic                           res_valid,
    output logic                           res_found,
    output logic [brf_pkg::POS_W-1:0]      res_position,
    input  wire logic                      res_ready
);
    import brf_pkg::*;

    localparam int WIDX = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int OW   = $clog2(WORD_W + 1);

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RUN,
        ST_FINISH
    } state_t;

    state_t               state_reg;
    cmd_t                 cur_reg;
    // One bit wider than a range end so that stepping past the last word
    // never wraps back below the end of the range.
    logic [END_W:0]       base_reg;
    logic [WIDX-1:0]      word_reg;
    logic [WIDX-1:0]      clr_reg;
    logic                 p_valid_reg;
    logic [END_W-1:0]     p_base_reg;
    logic [WIDX-1:0]      p_word_reg;
    logic                 found_reg;
    logic [POS_W-1:0]     pos_reg;
    logic                 out_valid_reg;
    logic                 out_found_reg;
    logic [POS_W-1:0]     out_pos_reg;

    logic [WORD_W-1:0]    mem [NUM_WORDS];
    logic [WORD_W-1:0]    rd_data_reg;

    logic                 issue;
    logic [OW-1:0]        lo_off;
    logic [OW-1:0]        hi_off;
    logic [WORD_W-1:0]    in_range;
    logic [WORD_W-1:0]    hit;
    logic                 any_hit;
    logic [OW-1:0]        hit_off;
    logic [END_W-1:0]     hit_pos;
    logic [WORD_W-1:0]    fill_word;
    logic                 mem_we;
    logic [WIDX-1:0]      mem_waddr;
    logic [WORD_W-1:0]    mem_wdata;
    logic                 out_free;

    assign issue    = (state_reg == ST_RUN) && (base_reg < {1'b0, cur_reg.range_end});
    assign q_pop    = (state_reg == ST_IDLE) && q_valid;
    assign out_free = !out_valid_reg || res_ready;

    // Offsets of the range limits inside the word being processed.
    always_comb
    begin
        logic [END_W-1:0] start_ext;
        logic [END_W-1:0] diff_lo;
        logic [END_W-1:0] diff_hi;
        start_ext = {1'b0, cur_reg.range_start};
        diff_lo   = start_ext - p_base_reg;
        diff_hi   = cur_reg.range_end - p_base_reg;
        if (start_ext <= p_base_reg)
        begin
            lo_off = '0;
        end
        else if (diff_lo >= END_W'(WORD_W))
        begin
            lo_off = OW'(WORD_W);
        end
        else
        begin
            lo_off = diff_lo[OW-1:0];
        end
        if (cur_reg.range_end <= p_base_reg)
        begin
            hi_off = '0;
        end
        else if (diff_hi >= END_W'(WORD_W))
        begin
            hi_off = OW'(WORD_W);
        end
        else
        begin
            hi_off = diff_hi[OW-1:0];
        end
    end

    // Offset o counts from the most significant bit of the word.
    always_comb
    begin
        for (int o = 0; o < WORD_W; o++)
        begin
            in_range[o] = (OW'(o) >= lo_off) && (OW'(o) < hi_off);
            hit[o]      = in_range[o] && (rd_data_reg[WORD_W-1-o] == cur_reg.bit_value);
            fill_word[WORD_W-1-o] = in_range[o] ? cur_reg.bit_value
                                                : rd_data_reg[WORD_W-1-o];
        end
    end

    always_comb
    begin
        any_hit = |hit;
        hit_off = '0;
        for (int o = WORD_W - 1; o >= 0; o--)
        begin
            if (hit[o])
            begin
                hit_off = OW'(o);
            end
        end
        hit_pos = p_base_reg + END_W'(hit_off);
    end

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = p_word_reg;
        mem_wdata = fill_word;
        if (state_reg == ST_CLEAR)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_reg;
            mem_wdata = '0;
        end
        else if ((state_reg == ST_RUN) && p_valid_reg && (cur_reg.op == OP_FILL))
        begin
            mem_we = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[word_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            p_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            base_reg      <= '0;
            word_reg      <= '0;
        end
        else
        begin
            p_valid_reg <= 1'b0;
            if (out_valid_reg && res_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_CLEAR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == WIDX'(NUM_WORDS - 1))
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    if (q_valid)
                    begin
                        cur_reg   <= q_cmd;
                        base_reg  <= '0;
                        word_reg  <= '0;
                        found_reg <= 1'b0;
                        pos_reg   <= '0;
                        state_reg <= (q_cmd.op == OP_NONE) ? ST_FINISH : ST_RUN;
                    end
                end
                ST_RUN:
                begin
                    if (issue)
                    begin
                        base_reg    <= base_reg + (END_W + 1)'(WORD_W);
                        word_reg    <= word_reg + 1'b1;
                        p_valid_reg <= 1'b1;
                        p_base_reg  <= base_reg[END_W-1:0];
                        p_word_reg  <= word_reg;
                    end
                    if (p_valid_reg && (cur_reg.op == OP_FIND) && any_hit)
                    begin
                        found_reg   <= 1'b1;
                        pos_reg     <= hit_pos[POS_W-1:0];
                        p_valid_reg <= 1'b0;
                        state_reg   <= ST_FINISH;
                    end
                    else if (!issue && !p_valid_reg)
                    begin
                        state_reg <= ST_FINISH;
                    end
                end
                ST_FINISH:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_found_reg <= found_reg;
                        out_pos_reg   <= pos_reg;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign res_valid    = out_valid_reg;
    assign res_found    = out_found_reg;
    assign res_position = out_pos_reg;

    // Store writes outside the clearing pass come only from fill commands.
    a_write_is_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (mem_we && state_reg != ST_CLEAR) |-> cur_reg.op == OP_FILL)
        else $error("store written by a command that is not a fill");

    // A word in flight only exists while a command walks the store.
    a_pipe_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        p_valid_reg |-> state_reg == ST_RUN)
        else $error("word in flight outside the walk");

    // A finished command lands in the output register once it is free.
    a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINISH && out_free) |=> res_valid)
        else $error("finished result not presented");

    // No command leaves the queue during the clearing pass.
    a_no_pop_clear: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_CLEAR |-> !q_pop)
        else $error("command taken during clearing pass");

endmodule

`default_nettype wire

// File: tb/sv/bitmap_range_find_and_fill_unit_tb.sv
// Testbench for the bitmap range find and fill unit: random and directed find and fill
// commands, with a shadow bitmap in a scoreboard class that predicts every result.
// Depends on brf_pkg and bitmap_range_find_and_fill_unit.
`timescale 1ns / 100ps

module bitmap_range_find_and_fill_unit_tb;

    localparam int WORD_W     = 64;
    localparam int NUM_WORDS  = 64;
    localparam int STORE_BITS = WORD_W * NUM_WORDS;

    // Stimulus size and the watchdog. The limit covers the slowest legal run
    // of every command together with receiver stalls and sender gaps.
    localparam int RANDOM_COMMANDS = 1130;
    localparam int CYCLE_LIMIT     = 800000;
    localparam int MAX_REPORTS     = 40;

    // One expected result transfer.
    typedef struct packed {
        logic                        found;
        logic [brf_pkg::POS_W-1:0]   position;
    } bitmap_result_t;

    // The scoreboard holds a shadow copy of the bitmap. Every accepted
    // command is applied to it at once, so the expected result of a find
    // reflects all fills accepted before it, which matches the in-order
    // execution of the unit.
    class bitmap_scoreboard;
        logic [WORD_W-1:0]    shadow_words [NUM_WORDS];
        bitmap_result_t       pending_results [$];
        int                   mismatches;
        int                   results_seen;
        int                   finds;
        int                   fills;
        int                   hits;
        int                   empty_ranges;

        function new();
            foreach (shadow_words[i])
                shadow_words[i] = '0;
            mismatches   = 0;
            results_seen = 0;
            finds        = 0;
            fills        = 0;
            hits         = 0;
            empty_ranges = 0;
        endfunction

        // Positions count from the most significant bit of each word.
        function logic shadow_bit(int pos);
            return shadow_words[pos / WORD_W][WORD_W - 1 - pos % WORD_W];
        endfunction

        function void note_command(logic cmd, logic [brf_pkg::START_W-1:0] range_start,
                                   logic [brf_pkg::END_W-1:0] range_end, logic bit_value);
            int             stop;
            bitmap_result_t res;
            // The end of the range is clamped to the size of the store.
            stop = (int'(range_end) > STORE_BITS) ? STORE_BITS : int'(range_end);
            res  = '0;
            if (int'(range_start) >= stop)
                empty_ranges++;
            if (cmd == brf_pkg::CMD_FIND)
            begin
                finds++;
                for (int p = int'(range_start); p < stop; p++)
                begin
                    if (shadow_bit(p) == bit_value)
                    begin
                        res.found    = 1'b1;
                        res.position = brf_pkg::POS_W'(p);
                        break;
                    end
                end
                if (res.found)
                    hits++;
            end
            else
            begin
                fills++;
                for (int p = int'(range_start); p < stop; p++)
                    shadow_words[p / WORD_W][WORD_W - 1 - p % WORD_W] = bit_value;
            end
            pending_results.push_back(res);
        endfunction

        task report_mismatch(string what);
            if (mismatches < MAX_REPORTS)
                $display("%0t: mismatch: %s", $time, what);
            mismatches++;
        endtask

        task check_result(logic found, logic [brf_pkg::POS_W-1:0] position);
            bitmap_result_t want;
            results_seen++;
            if (pending_results.size() == 0)
            begin
                report_mismatch($sformatf("result found=%0b position=%0d with none pending",
                                          found, position));
                return;
            end
            want = pending_results.pop_front();
            if (found !== want.found)
                report_mismatch($sformatf("result %0d: found=%0b, expected %0b",
                                          results_seen, found, want.found));
            if (position !== want.position)
                report_mismatch($sformatf("result %0d: position=%0d, expected %0d",
                                          results_seen, position, want.position));
        endtask
    endclass

    logic                         clk;
    logic                         rst_n;
    logic                         s_axis_tvalid;
    logic                         s_axis_tready;
    logic [brf_pkg::S_DATA_W-1:0] s_axis_tdata;
    logic                         s_axis_tuser;
    logic                         m_axis_tvalid;
    logic                         m_axis_tready;
    logic [brf_pkg::M_DATA_W-1:0] m_axis_tdata;
    logic                         m_axis_tuser;

    bitmap_scoreboard sb = new();

    // Percent chance per cycle that the command sender or the result
    // receiver holds off; changed between phases of the run.
    int  send_idle_pct;
    int  recv_idle_pct;
    int  cycle_count;

    bitmap_range_find_and_fill_unit #(
        .WORD_W    (WORD_W),
        .NUM_WORDS (NUM_WORDS)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #5 clk = ~clk;

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, sb.pending_results.size());
            $display("FAIL bitmap_range_find_and_fill_unit");
            $finish;
        end
    end

    // The receiver decides its ready for the next edge at each falling edge.
    always @(negedge clk)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // A result transfer happens at a rising edge with valid and ready high.
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tuser, m_axis_tdata[brf_pkg::POS_W-1:0]);
    end

    // Offers one command and returns once its transfer has taken place.
    // Idle cycles come before the command; once valid is raised it stays
    // high until accepted, as the stream protocol requires.
    task send_command(logic cmd, int range_start, int range_end, logic bit_value);
        logic [brf_pkg::START_W-1:0] start_f;
        logic [brf_pkg::END_W-1:0]   end_f;
        start_f = brf_pkg::START_W'(range_start);
        end_f   = brf_pkg::END_W'(range_end);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {{(brf_pkg::S_DATA_W - 26){1'b0}}, bit_value, end_f, start_f};
        do
            @(posedge clk);
        while (!s_axis_tready);
        sb.note_command(cmd, start_f, end_f, bit_value);
    endtask

    // Short directed sequence: full and clamped ranges, empty ranges of both
    // kinds, word boundaries, the last position, and finds that hit and miss.
    task run_directed();
        send_command(brf_pkg::CMD_FIND, 0, 4096, 1'b1);    // fresh store: no ones
        send_command(brf_pkg::CMD_FIND, 0, 4096, 1'b0);    // first zero at 0
        send_command(brf_pkg::CMD_FIND, 4095, 4096, 1'b0); // last position alone
        send_command(brf_pkg::CMD_FILL, 0, 4096, 1'b1);    // whole store to ones
        send_command(brf_pkg::CMD_FIND, 0, 8191, 1'b0);    // clamped end, no match
        send_command(brf_pkg::CMD_FIND, 4095, 8191, 1'b1);
        send_command(brf_pkg::CMD_FILL, 100, 200, 1'b0);
        send_command(brf_pkg::CMD_FIND, 0, 4096, 1'b0);
        send_command(brf_pkg::CMD_FIND, 100, 4096, 1'b1);
        send_command(brf_pkg::CMD_FIND, 150, 150, 1'b0);   // start equal to end
        send_command(brf_pkg::CMD_FIND, 300, 10, 1'b1);    // start above end
        send_command(brf_pkg::CMD_FILL, 4095, 4095, 1'b0); // empty fill at the top
        send_command(brf_pkg::CMD_FILL, 200, 100, 1'b0);   // reversed fill does nothing
        send_command(brf_pkg::CMD_FIND, 199, 201, 1'b1);
        send_command(brf_pkg::CMD_FILL, 63, 65, 1'b0);     // straddles a word boundary
        send_command(brf_pkg::CMD_FIND, 0, 4096, 1'b0);
        send_command(brf_pkg::CMD_FIND, 65, 4096, 1'b0);
        send_command(brf_pkg::CMD_FILL, 4000, 8191, 1'b0); // clamped fill
        send_command(brf_pkg::CMD_FIND, 3999, 4096, 1'b0);
        send_command(brf_pkg::CMD_FILL, 0, 0, 1'b1);       // empty at position 0
        send_command(brf_pkg::CMD_FILL, 0, 4096, 1'b0);    // clear everything
        send_command(brf_pkg::CMD_FIND, 0, 4096, 1'b1);
        send_command(brf_pkg::CMD_FILL, 4095, 4096, 1'b1);
        send_command(brf_pkg::CMD_FIND, 0, 4096, 1'b1);
    endtask

    // Random commands. Most ranges are short and well formed so that the
    // bitmap fills up with runs of both values; the rest reach to or past the
    // end of the store, end at a random point or are empty.
    task run_random(int count);
        logic cmd;
        int   range_start;
        int   range_end;
        int   pick;
        for (int i = 0; i < count; i++)
        begin
            cmd = ($urandom_range(99) < 40) ? brf_pkg::CMD_FILL : brf_pkg::CMD_FIND;
            range_start = ($urandom_range(99) < 15) ? $urandom_range(127)
                                                    : $urandom_range(4095);
            pick = $urandom_range(99);
            if (pick < 65)
                range_end = range_start + $urandom_range(400, 1);
            else if (pick < 75)
                range_end = $urandom_range(8191, 4096);
            else if (pick < 85)
                range_end = $urandom_range(8191);
            else
                range_end = range_start - $urandom_range((range_start < 50) ? range_start : 50);
            send_command(cmd, range_start, range_end, 1'($urandom_range(1)));
        end
    endtask

    initial
    begin
        clk           = 1'b0;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = brf_pkg::CMD_FIND;
        m_axis_tready = 1'b0;
        cycle_count   = 0;
        send_idle_pct = 24;
        recv_idle_pct = 70;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Phase one: sender idles now and then, receiver stalls heavily.
        run_directed();
        run_random(RANDOM_COMMANDS / 3);

        // Phase two: the roles swap.
        send_idle_pct = 70;
        recv_idle_pct = 24;
        run_random(RANDOM_COMMANDS / 3);

        // Phase three: back-to-back traffic on both sides.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random(RANDOM_COMMANDS - 2 * (RANDOM_COMMANDS / 3));

        @(negedge clk);
        s_axis_tvalid <= 1'b0;

        // Drain the outstanding results, then keep watching the result port for
        // any stray transfer to show up.
        while (sb.pending_results.size() != 0)
            @(posedge clk);
        repeat (NUM_WORDS + 8) @(posedge clk);

        foreach (sb.pending_results[i])
            sb.report_mismatch($sformatf("expected result %0d never arrived", i));

        $display("Covered %0d finds (%0d with a match) and %0d fills, %0d of them empty ranges,",
                 sb.finds, sb.hits, sb.fills, sb.empty_ranges);
        $display("under three stall patterns; %0d results checked, %0d mismatches.",
                 sb.results_seen, sb.mismatches);
        if (sb.mismatches == 0)
            $display("PASS bitmap_range_find_and_fill_unit");
        else
            $display("FAIL bitmap_range_find_and_fill_unit");
        $finish;
    end

endmodule

// File: sim.f
hw/rtl/brf_pkg.sv
hw/rtl/brf_front.sv
hw/rtl/brf_queue.sv
hw/rtl/brf_back.sv
hw/rtl/bitmap_range_find_and_fill_unit.sv
tb/sv/bitmap_range_find_and_fill_unit_tb.sv
